>>> rtl/sega_pkg.sv
// shared types and codes for the segment allocator
`timescale 1ns / 1ps

package sega_pkg;

   // fixed field widths of the request and response words
   localparam int ADDR_W = 10;
   localparam int SIZE_W = 11;
   localparam int STATUS_W = 2;

   // request operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFIT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BADADDR = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   typedef struct packed {
      logic              op;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] free_address;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   granted_address;
   } rsp_word_type;

endpackage

>>> rtl/sega_ram.sv
// single-port-write, single-port-read segment table memory with registered read
`timescale 1ns / 1ps

module sega_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 22,
   parameter int IDX_W = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/segment_allocator_first_best_fit.sv
// top level of the first-fit / best-fit segment allocator
`timescale 1ns / 1ps

// Segment allocator over MEM_SIZE units. The segment table lives in one memory
// with a registered read port, and a small sequencer walks it entry by entry
// (read, then compare). An allocate scans up to the whole table (first fit
// stops at the first hit), then shifts every later entry up by one when it
// splits a segment; a free scans up to the matching entry, reads its right
// neighbour if there is one, and shifts later entries down when it merges. A
// zero-size allocate is answered with STATUS_NOFIT from idle, without a scan.
// busy is high while any other request is handled, and after reset while the
// first table entry is written. Each result is shown for exactly one cycle on
// rsp_strobe and cannot be held off. The user must write fit_mode through
// csr_write_enable only while the block is idle; the block itself does not
// enforce it.
module segment_allocator_first_best_fit #(
   parameter int MEM_SIZE     = 1024,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sega_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output sega_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data
);

   import sega_pkg::*;

   localparam int IW   = $clog2(MAX_SEGMENTS);
   localparam int CW   = $clog2(MAX_SEGMENTS + 1);
   localparam int AW   = $clog2(MEM_SIZE);
   localparam int LW   = $clog2(MEM_SIZE + 1);
   localparam int EW   = AW + LW + 1;
   localparam int CMPW = (LW > SIZE_W) ? LW : SIZE_W;
   localparam int FAW  = (AW > ADDR_W) ? AW : ADDR_W;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_RD,
      ST_EV,
      ST_DEC,
      ST_MRD,
      ST_MWR,
      ST_SPLIT,
      ST_SPLIT2,
      ST_NRD,
      ST_NEV,
      ST_MERGE
   } state_type;

   state_type state_ff, state_in;
   logic              op_ff, op_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] faddr_ff, faddr_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     src_ff, src_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              found_ff, found_in;
   logic [CW-1:0]     pick_ff, pick_in;
   logic [AW-1:0]     pick_start_ff, pick_start_in;
   logic [LW-1:0]     pick_len_ff, pick_len_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [AW-1:0]     cur_start_ff, cur_start_in;
   logic [LW-1:0]     cur_len_ff, cur_len_in;
   logic [AW-1:0]     prev_start_ff, prev_start_in;
   logic [LW-1:0]     prev_len_ff, prev_len_in;
   logic              prev_busy_ff, prev_busy_in;
   logic              next_free_ff, next_free_in;
   logic [LW-1:0]     next_len_ff, next_len_in;
   logic [1:0]        dist_ff, dist_in;
   logic              up_ff, up_in;
   logic              fit_ff, fit_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   // table memory port signals
   logic          wr_en;
   logic [IW-1:0] wr_idx;
   logic [EW-1:0] wr_data;
   logic [IW-1:0] rd_idx;
   logic [EW-1:0] rd_data;

   logic [AW-1:0] rd_start;
   logic [LW-1:0] rd_len;
   logic          rd_busy;
   logic          fits, better, last, match, pf, nf;
   logic [CW-1:0] dst;
   logic [CW-1:0] msrc;
   logic [LW-1:0] merge_len;

   sega_ram #(
      .DEPTH (MAX_SEGMENTS),
      .WIDTH (EW),
      .IDX_W (IW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   // unpack the entry just read
   assign rd_start = rd_data[EW-1 -: AW];
   assign rd_len   = rd_data[LW:1];
   assign rd_busy  = rd_data[0];

   // scan compares
   assign fits   = !rd_busy && (CMPW'(rd_len) >= CMPW'(size_ff));
   assign better = !found_ff || (rd_len < pick_len_ff);
   assign last   = ((idx_ff + CW'(1)) == count_ff);
   assign match  = (FAW'(rd_start) == FAW'(faddr_ff));

   // merge terms
   assign pf        = (pos_ff != '0) && !prev_busy_ff;
   assign nf        = next_free_ff;
   assign merge_len = LW'((pf ? prev_len_ff : LW'(0)) + cur_len_ff
                          + (nf ? next_len_ff : LW'(0)));
   assign msrc      = pos_ff + CW'(1) + CW'(nf);

   // move destination for the shared shift loop
   assign dst = up_ff ? (src_ff + CW'(1)) : (src_ff - CW'(dist_ff));

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      faddr_in      = faddr_ff;
      idx_in        = idx_ff;
      src_in        = src_ff;
      count_in      = count_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      pick_start_in = pick_start_ff;
      pick_len_in   = pick_len_ff;
      pos_in        = pos_ff;
      cur_start_in  = cur_start_ff;
      cur_len_in    = cur_len_ff;
      prev_start_in = prev_start_ff;
      prev_len_in   = prev_len_ff;
      prev_busy_in  = prev_busy_ff;
      next_free_in  = next_free_ff;
      next_len_in   = next_len_ff;
      dist_in       = dist_ff;
      up_in         = up_ff;
      fit_in        = fit_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      wr_en         = 1'b0;
      wr_idx        = '0;
      wr_data       = '0;
      rd_idx        = '0;

      if (csr_write_enable) begin
         fit_in = csr_write_data;
      end

      unique case (state_ff)
         ST_INIT: begin
            wr_en    = 1'b1;
            wr_data  = {AW'(0), LW'(MEM_SIZE), 1'b0};
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               op_in    = req_word.op;
               size_in  = req_word.request_size;
               faddr_in = req_word.free_address;
               idx_in   = '0;
               found_in = 1'b0;
               if (req_word.op == OP_ALLOC && req_word.request_size == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_NOFIT;
                  rsp_addr_in   = '0;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            rd_idx   = idx_ff[IW-1:0];
            state_in = ST_EV;
         end
         ST_EV: begin
            if (op_ff == OP_ALLOC) begin
               if (fits && better) begin
                  found_in      = 1'b1;
                  pick_in       = idx_ff;
                  pick_start_in = rd_start;
                  pick_len_in   = rd_len;
               end
               if ((fits && !fit_ff) || last) begin
                  state_in = ST_DEC;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ST_RD;
               end
            end else begin
               if (match) begin
                  pos_in       = idx_ff;
                  cur_start_in = rd_start;
                  cur_len_in   = rd_len;
                  if (!rd_busy) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_BADADDR;
                     rsp_addr_in   = '0;
                     state_in      = ST_IDLE;
                  end else if (!last) begin
                     state_in = ST_NRD;
                  end else begin
                     next_free_in = 1'b0;
                     state_in     = ST_MERGE;
                  end
               end else begin
                  prev_start_in = rd_start;
                  prev_len_in   = rd_len;
                  prev_busy_in  = rd_busy;
                  if (last) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_BADADDR;
                     rsp_addr_in   = '0;
                     state_in      = ST_IDLE;
                  end else begin
                     idx_in   = idx_ff + CW'(1);
                     state_in = ST_RD;
                  end
               end
            end
         end
         ST_DEC: begin
            priority if (!found_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_NOFIT;
               rsp_addr_in   = '0;
               state_in      = ST_IDLE;
            end else if (CMPW'(pick_len_ff) == CMPW'(size_ff)) begin
               // exact fit: mark busy in place
               wr_en         = 1'b1;
               wr_idx        = pick_ff[IW-1:0];
               wr_data       = {pick_start_ff, pick_len_ff, 1'b1};
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_addr_in   = ADDR_W'(pick_start_ff);
               state_in      = ST_IDLE;
            end else if (count_ff == CW'(MAX_SEGMENTS)) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_FULL;
               rsp_addr_in   = '0;
               state_in      = ST_IDLE;
            end else if (count_ff > pick_ff + CW'(1)) begin
               src_in   = count_ff - CW'(1);
               up_in    = 1'b1;
               state_in = ST_MRD;
            end else begin
               state_in = ST_SPLIT;
            end
         end
         ST_MRD: begin
            rd_idx   = src_ff[IW-1:0];
            state_in = ST_MWR;
         end
         ST_MWR: begin
            wr_en   = 1'b1;
            wr_idx  = dst[IW-1:0];
            wr_data = rd_data;
            if (up_ff) begin
               if (src_ff == pick_ff + CW'(1)) begin
                  state_in = ST_SPLIT;
               end else begin
                  src_in   = src_ff - CW'(1);
                  state_in = ST_MRD;
               end
            end else begin
               if (src_ff + CW'(1) == count_ff) begin
                  count_in      = count_ff - CW'(dist_ff);
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_addr_in   = '0;
                  state_in      = ST_IDLE;
               end else begin
                  src_in   = src_ff + CW'(1);
                  state_in = ST_MRD;
               end
            end
         end
         ST_SPLIT: begin
            // remainder goes just after the picked entry
            wr_en    = 1'b1;
            wr_idx   = IW'(pick_ff + CW'(1));
            wr_data  = {AW'(pick_start_ff + AW'(size_ff)),
                        LW'(pick_len_ff - LW'(size_ff)), 1'b0};
            state_in = ST_SPLIT2;
         end
         ST_SPLIT2: begin
            wr_en         = 1'b1;
            wr_idx        = pick_ff[IW-1:0];
            wr_data       = {pick_start_ff, LW'(size_ff), 1'b1};
            count_in      = count_ff + CW'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_addr_in   = ADDR_W'(pick_start_ff);
            state_in      = ST_IDLE;
         end
         ST_NRD: begin
            rd_idx   = IW'(pos_ff + CW'(1));
            state_in = ST_NEV;
         end
         ST_NEV: begin
            next_free_in = !rd_busy;
            next_len_in  = rd_len;
            state_in     = ST_MERGE;
         end
         ST_MERGE: begin
            // write the coalesced free segment, then close the gap
            wr_en   = 1'b1;
            wr_idx  = pf ? IW'(pos_ff - CW'(1)) : pos_ff[IW-1:0];
            wr_data = {(pf ? prev_start_ff : cur_start_ff), merge_len, 1'b0};
            dist_in = 2'(pf) + 2'(nf);
            src_in  = msrc;
            up_in   = 1'b0;
            if ((pf || nf) && msrc < count_ff) begin
               state_in = ST_MRD;
            end else begin
               count_in      = count_ff - CW'(2'(pf) + 2'(nf));
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_addr_in   = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         count_ff      <= CW'(1);
         fit_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         found_ff      <= 1'b0;
         up_ff         <= 1'b0;
         dist_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         fit_ff        <= fit_in;
         rsp_strobe_ff <= rsp_strobe_in;
         found_ff      <= found_in;
         up_ff         <= up_in;
         dist_ff       <= dist_in;
      end
      op_ff         <= op_in;
      size_ff       <= size_in;
      faddr_ff      <= faddr_in;
      idx_ff        <= idx_in;
      src_ff        <= src_in;
      pick_ff       <= pick_in;
      pick_start_ff <= pick_start_in;
      pick_len_ff   <= pick_len_in;
      pos_ff        <= pos_in;
      cur_start_ff  <= cur_start_in;
      cur_len_ff    <= cur_len_in;
      prev_start_ff <= prev_start_in;
      prev_len_ff   <= prev_len_in;
      prev_busy_ff  <= prev_busy_in;
      next_free_ff  <= next_free_in;
      next_len_ff   <= next_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   // ports
   assign busy                     = (state_ff != ST_IDLE);
   assign rsp_strobe               = rsp_strobe_ff;
   assign rsp_word.status          = rsp_status_ff;
   assign rsp_word.granted_address = rsp_addr_ff;

endmodule
